/* sv/lrqss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrqss_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int FUNC_W = 2;
	localparam int HANDLE_W = 16;
	localparam int KIND_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_STEAL = 2'd2
	} func_t;

	localparam logic [KIND_W-1:0] KIND_PUSHED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POPPED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SPILLED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STOLEN  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_OUT,
		ST_PUSH,
		ST_EMPTY
	} state_t;

	typedef enum logic [1:0] {
		MODE_SPILL,
		MODE_POP,
		MODE_STEAL
	} mode_t;

	typedef enum logic [1:0] {
		CNT_ONE,
		CNT_HALF,
		CNT_STEAL
	} cnt_src_t;

	typedef struct packed {
		logic              accept;
		logic              cnt_ld;
		cnt_src_t          cnt_src;
		logic              rd_en;
		logic              wr_en;
		logic              out_load;
		logic              out_from_mem;
		logic [KIND_W-1:0] out_kind;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic cnt_zero;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* sv/lrqss_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrqss_dp
	import lrqss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	input  wire logic [HANDLE_W-1:0] in_handle,
	output sts_t                     sts,
	output logic                     m_valid,
	input  wire logic                m_ready,
	output logic [HANDLE_W-1:0]      m_handle,
	output logic [KIND_W-1:0]        m_kind,
	output logic                     m_last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2((CAPACITY + 1) / 2 + 1);

	logic [HANDLE_W-1:0] mem [CAPACITY];

	logic [AW-1:0]       hslot_q, tslot_q;
	logic                hlap_q, tlap_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [HANDLE_W-1:0] rdata_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic                out_last_q;

	logic [SW-1:0]       size;
	logic [SW-1:0]       steal_n;
	logic                slots_eq;

	assign slots_eq = (hslot_q == tslot_q);

	always_comb begin
		if (hlap_q == tlap_q) begin
			size = SW'(tslot_q) - SW'(hslot_q);
		end else begin
			size = SW'(CAPACITY) - SW'(hslot_q) + SW'(tslot_q);
		end
		steal_n = size - (size >> 1);
	end

	assign sts.full     = slots_eq && (hlap_q != tlap_q);
	assign sts.empty    = slots_eq && (hlap_q == tlap_q);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || m_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			handle_q <= in_handle;
		end
		if (cmd.wr_en) begin
			mem[tslot_q] <= handle_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[hslot_q];
		end
		if (cmd.out_load) begin
			out_handle_q <= cmd.out_from_mem ? rdata_q : '0;
			out_kind_q   <= cmd.out_kind;
			out_last_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hslot_q     <= '0;
			hlap_q      <= 1'b0;
			tslot_q     <= '0;
			tlap_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// advance head on every read, decrement remaining count
			if (cmd.rd_en) begin
				if (hslot_q == AW'(CAPACITY - 1)) begin
					hslot_q <= '0;
					hlap_q  <= !hlap_q;
				end else begin
					hslot_q <= hslot_q + AW'(1);
				end
			end
			if (cmd.wr_en) begin
				if (tslot_q == AW'(CAPACITY - 1)) begin
					tslot_q <= '0;
					tlap_q  <= !tlap_q;
				end else begin
					tslot_q <= tslot_q + AW'(1);
				end
			end
			if (cmd.cnt_ld) begin
				case (cmd.cnt_src)
					CNT_ONE:   cnt_q <= CW'(1);
					CNT_HALF:  cnt_q <= CW'(CAPACITY / 2);
					CNT_STEAL: cnt_q <= CW'(steal_n);
					default:   cnt_q <= CW'(1);
				endcase
			end else if (cmd.rd_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid  = out_valid_q;
	assign m_handle = out_handle_q;
	assign m_kind   = out_kind_q;
	assign m_last   = out_last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output beat overwritten before taken");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !sts.full)
		else $error("write into full ring");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !sts.empty)
		else $error("read from empty ring");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |=> (size == $past(size) + SW'(1)) || $past(cmd.rd_en))
		else $error("ring size did not follow write");

endmodule

`default_nettype wire

/* sv/lrqss_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrqss_ctrl
	import lrqss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	input  wire logic [FUNC_W-1:0] s_func,
	output logic                   s_ready,
	input  wire sts_t              sts,
	output cmd_t                   cmd
);

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_POP;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		s_ready = 1'b0;
		cmd     = '{accept: 1'b0, cnt_ld: 1'b0, cnt_src: CNT_ONE, rd_en: 1'b0,
			wr_en: 1'b0, out_load: 1'b0, out_from_mem: 1'b0,
			out_kind: KIND_PUSHED, out_last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				s_ready    = 1'b1;
				cmd.accept = s_valid;
				if (s_valid) begin
					case (s_func)
						FUNC_PUSH: begin
							if (sts.full) begin
								cmd.cnt_ld  = 1'b1;
								cmd.cnt_src = CNT_HALF;
								mode_d      = MODE_SPILL;
								state_d     = ST_RD;
							end else begin
								state_d = ST_PUSH;
							end
						end
						FUNC_POP: begin
							if (sts.empty) begin
								state_d = ST_EMPTY;
							end else begin
								cmd.cnt_ld  = 1'b1;
								cmd.cnt_src = CNT_ONE;
								mode_d      = MODE_POP;
								state_d     = ST_RD;
							end
						end
						FUNC_STEAL: begin
							if (sts.empty) begin
								state_d = ST_EMPTY;
							end else begin
								cmd.cnt_ld  = 1'b1;
								cmd.cnt_src = CNT_STEAL;
								mode_d      = MODE_STEAL;
								state_d     = ST_RD;
							end
						end
						default: begin
							// unused code: drop the beat
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					case (mode_q)
						MODE_SPILL: cmd.out_kind = KIND_SPILLED;
						MODE_POP:   cmd.out_kind = KIND_POPPED;
						MODE_STEAL: cmd.out_kind = KIND_STOLEN;
						default:    cmd.out_kind = KIND_POPPED;
					endcase
					cmd.out_last = (mode_q != MODE_SPILL) && sts.cnt_zero;
					// overlap the next read with this output load
					if (!sts.cnt_zero) begin
						cmd.rd_en = 1'b1;
					end else if (mode_q == MODE_SPILL) begin
						state_d = ST_PUSH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_PUSHED;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_EMPTY;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/local_run_queue_spill_steal_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Owner side of a bounded ring run queue of 16-bit task handles. A push
// stores the handle at the tail; on a full ring it first spills the oldest
// CAPACITY/2 handles as overflow beats. A pop gives the head handle or an
// empty beat; a steal gives ceil(size/2) handles from the head with tlast
// on the final one, or one empty beat. Every input beat of a used code ends
// with a beat carrying tlast; unused operation codes are dropped with no
// output. One operation runs at a time and handles come out of a single-port
// ring with registered read data, one per cycle once streaming and while the
// output side does not stall. The ring contents need no clearing after
// reset; of the ring's state only the head and tail positions reset.
module local_run_queue_spill_steal_top
	import lrqss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] task_handle
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [15:0] out_handle
	output logic [2:0]       m_axis_tuser,  // [2:0] kind
	output logic             m_axis_tlast
);

	cmd_t cmd;
	sts_t sts;

	lrqss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_func  (s_axis_tuser),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lrqss_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_handle (s_axis_tdata),
		.sts       (sts),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_handle  (m_axis_tdata),
		.m_kind    (m_axis_tuser),
		.m_last    (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import lrqss_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int POS_W = $clog2(2 * CAP);
	localparam int SLOT_W = $clog2(CAP);
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 146;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KIND_W-1:0]   kind;
		logic                last;
	} run_beat_t;

	class run_queue_scoreboard;
		logic [HANDLE_W-1:0] ring[CAP];
		logic [POS_W-1:0]    head_pos;
		logic [POS_W-1:0]    tail_pos;
		run_beat_t           due_beats[$];
		int errors;
		int beats_checked;
		int items_taken;
		int spill_runs;
		int steal_runs;
		int empty_beats;
		int ignored_items;

		function new();
			head_pos = '0;
			tail_pos = '0;
		endfunction

		function int occupancy();
			logic [POS_W-1:0] diff;
			diff = tail_pos - head_pos;
			return int'(diff);
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function run_beat_t beat(logic [HANDLE_W-1:0] h, logic [KIND_W-1:0] k, logic l);
			run_beat_t b;
			b.handle = h;
			b.kind = k;
			b.last = l;
			return b;
		endfunction

		function logic [HANDLE_W-1:0] take_head();
			logic [HANDLE_W-1:0] h;
			h = ring[head_pos[SLOT_W-1:0]];
			head_pos = head_pos + 1'b1;
			return h;
		endfunction

		// Apply one accepted input beat and queue the beats it must produce.
		function void note_input(logic [FUNC_W-1:0] op, logic [HANDLE_W-1:0] h);
			int fill;
			int count;
			int i;
			fill = occupancy();
			items_taken++;
			case (op)
				FUNC_PUSH: begin
					if (fill >= CAP) begin
						spill_runs++;
						for (i = 0; i < CAP / 2; i++)
							due_beats.push_back(beat(take_head(), KIND_SPILLED, 1'b0));
					end
					ring[tail_pos[SLOT_W-1:0]] = h;
					tail_pos = tail_pos + 1'b1;
					due_beats.push_back(beat('0, KIND_PUSHED, 1'b1));
				end
				FUNC_POP: begin
					if (fill == 0) begin
						empty_beats++;
						due_beats.push_back(beat('0, KIND_EMPTY, 1'b1));
					end else begin
						due_beats.push_back(beat(take_head(), KIND_POPPED, 1'b1));
					end
				end
				FUNC_STEAL: begin
					if (fill == 0) begin
						empty_beats++;
						due_beats.push_back(beat('0, KIND_EMPTY, 1'b1));
					end else begin
						steal_runs++;
						count = fill - fill / 2;
						for (i = 0; i < count; i++)
							due_beats.push_back(beat(take_head(), KIND_STOLEN, i + 1 == count));
					end
				end
				default: ignored_items++;
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task check_result(logic [HANDLE_W-1:0] h, logic [KIND_W-1:0] k, logic l);
			run_beat_t want;
			if (due_beats.size() == 0) begin
				report($sformatf("unexpected beat handle=%h kind=%0d last=%0b", h, k, l));
				return;
			end
			want = due_beats.pop_front();
			beats_checked++;
			if (h !== want.handle)
				report($sformatf("beat %0d handle %h, want %h", beats_checked, h, want.handle));
			if (k !== want.kind)
				report($sformatf("beat %0d kind %0d, want %0d", beats_checked, k, want.kind));
			if (l !== want.last)
				report($sformatf("beat %0d last %0b, want %0b", beats_checked, l, want.last));
		endtask

		task finish_check();
			if (due_beats.size() != 0)
				report($sformatf("%0d expected beats never arrived", due_beats.size()));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata;
	logic [1:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [15:0]         m_axis_tdata;
	logic [2:0]          m_axis_tuser;
	logic                m_axis_tlast;
	logic                quiet;
	int                  cycles;
	run_queue_scoreboard sb;

	local_run_queue_spill_steal_top #(
		.CAPACITY(CAP)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Output side: check each accepted beat, stall at random outside quiet stretches.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 18);
		end
	end

	task automatic send_item(input logic [FUNC_W-1:0] op, input logic [HANDLE_W-1:0] h);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 18) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= h;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, h);
	endtask

	// Hold input until every queued beat has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [HANDLE_W-1:0] rand_handle();
		return HANDLE_W'($urandom_range(1, 16'hFFFF));
	endfunction

	initial begin
		int sent;
		int len;
		int extra;
		int r;
		bit paused;
		logic [FUNC_W-1:0] op;

		sb = new();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		arst_n <= 1'b0;
		quiet <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, unused code, extreme handles, odd and even steals.
		send_item(FUNC_POP, 16'hFFFF);
		send_item(FUNC_STEAL, 16'h0000);
		send_item(FUNC_UNUSED, 16'hFFFF);
		send_item(FUNC_PUSH, 16'h0000);
		send_item(FUNC_PUSH, 16'hFFFF);
		send_item(FUNC_POP, 16'h0000);
		send_item(FUNC_STEAL, 16'hFFFF);
		send_item(FUNC_PUSH, 16'hAAAA);
		send_item(FUNC_PUSH, 16'h5555);
		send_item(FUNC_PUSH, 16'h1234);
		send_item(FUNC_STEAL, 16'h0000);
		send_item(FUNC_POP, 16'h0000);
		send_item(FUNC_POP, 16'h0000);
		send_item(FUNC_UNUSED, 16'h0000);
		repeat (5) send_item(FUNC_PUSH, rand_handle());
		send_item(FUNC_STEAL, 16'h0000);
		send_item(FUNC_STEAL, 16'h0000);
		send_item(FUNC_STEAL, 16'h0000);
		wait_drained();

		sent = 0;
		paused = 0;
		while (sent < RAND_ITEMS) begin
			if (sent == 0 ||
				($urandom_range(0, 99) < 8 && sent + CAP + 3 <= RAND_ITEMS)) begin
				// Fill the ring, then push past full to force spills.
				extra = $urandom_range(1, 3);
				while (sb.occupancy() < CAP) begin
					send_item(FUNC_PUSH, rand_handle());
					sent++;
				end
				repeat (extra) begin
					send_item(FUNC_PUSH, rand_handle());
					sent++;
				end
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 55)
						op = FUNC_PUSH;
					else if (r < 80)
						op = FUNC_POP;
					else if (r < 93)
						op = FUNC_STEAL;
					else
						op = FUNC_UNUSED;
					send_item(op, rand_handle());
					sent++;
				end
			end
			if (sent >= 110 && !paused) begin
				wait_drained();
				paused = 1;
			end
			quiet <= (sent >= 40 && sent < 100);
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (CAP / 2 + 8) @(posedge clk);
		sb.finish_check();

		$display("covered %0d input beats (%0d ignored), %0d output beats checked",
			sb.items_taken, sb.ignored_items, sb.beats_checked);
		$display("full-ring spills %0d, steals %0d, empty replies %0d",
			sb.spill_runs, sb.steal_runs, sb.empty_beats);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
